// ===== rtl/pcfa_pkg.sv =====
package pcfa_pkg;

    localparam int PAGE_W          = 15;
    localparam int CPU_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int LIST_W          = 6;   // holds a list index for up to 64 lists
    localparam int DEF_NUM_PAGES   = 32768;
    localparam int DEF_NUM_LISTS   = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_BAD   = 2'd2
    } op_t;

    // Classified request handed from the front end to the list engine.
    // For an allocate, list is the requesting cpu and pref says it names a list.
    // For a free, list is the partition the page belongs to.
    typedef struct packed {
        op_t                op;
        logic               pref;
        logic [LIST_W-1:0]  list;
        logic [PAGE_W-1:0]  page;
    } cmd_t;

endpackage

// ===== rtl/pcfa_front.sv =====
module pcfa_front import pcfa_pkg::*; #(
    parameter int NUM_PAGES = DEF_NUM_PAGES,
    parameter int NUM_LISTS = DEF_NUM_LISTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PAGE_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [CPU_W-1:0]    s_cpu_id,
    input  logic [PAGE_W-1:0]   s_page_in,
    output logic                q_push_valid,
    input  logic                q_push_ready,
    output cmd_t                q_push_data
);

    // compare width covers both the page field and NUM_PAGES itself
    localparam int CW = $clog2(NUM_PAGES) + PAGE_W + 1;

    logic [PAGE_W-1:0]      free_floor_reg;
    logic                   in_range;
    logic [NUM_LISTS-1:0]   above_thr;
    logic [LIST_W-1:0]      part;
    logic                   cpu_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_floor_reg <= '0;
        end else if (cfg_valid) begin
            free_floor_reg <= cfg_data;
        end
    end

    assign in_range = (s_page_in >= free_floor_reg) &&
                      (CW'(s_page_in) < CW'(NUM_PAGES));

    // partition = page * NUM_LISTS / NUM_PAGES, as a count of thresholds passed
    assign above_thr[0] = 1'b0;
    for (genvar k = 1; k < NUM_LISTS; k++) begin : g_thr
        localparam longint THR = (longint'(k) * NUM_PAGES + NUM_LISTS - 1) / NUM_LISTS;
        assign above_thr[k] = CW'(s_page_in) >= CW'(THR);
    end

    always_comb begin
        part = '0;
        for (int i = 0; i < NUM_LISTS; i++) begin
            part = part + LIST_W'(above_thr[i]);
        end
    end

    assign cpu_ok = (7'(s_cpu_id) < 7'(NUM_LISTS));

    always_comb begin
        q_push_data.page = s_page_in;
        if (s_req_type == REQ_FREE) begin
            q_push_data.op   = in_range ? OP_FREE : OP_BAD;
            q_push_data.pref = 1'b0;
            q_push_data.list = part;
        end else begin
            q_push_data.op   = OP_ALLOC;
            q_push_data.pref = cpu_ok;
            q_push_data.list = LIST_W'(s_cpu_id);
        end
    end

    assign q_push_valid = s_valid;
    assign s_ready      = q_push_ready;

endmodule

// ===== rtl/pcfa_queue.sv =====
module pcfa_queue import pcfa_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    output logic    push_ready,
    input  cmd_t    push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output cmd_t    pop_data
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== rtl/pcfa_back.sv =====
module pcfa_back import pcfa_pkg::*; #(
    parameter int NUM_PAGES = DEF_NUM_PAGES,
    parameter int NUM_LISTS = DEF_NUM_LISTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  cmd_t                q_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [PAGE_W-1:0]   m_page_out
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic                   state_reg;
    logic [NUM_LISTS-1:0]   nonempty_reg;
    logic [PAGE_W-1:0]      head_reg [NUM_LISTS];
    logic [LW-1:0]          pop_sel_reg;
    logic [PAGE_W:0]        link_mem [NUM_PAGES];
    logic [PAGE_W:0]        rd_data_reg;
    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [PAGE_W-1:0]      m_page_reg;

    logic                   out_free;
    logic                   take;
    logic [LW-1:0]          cmd_li;
    logic [LW-1:0]          low_li;
    logic [LW-1:0]          sel_li;
    logic [LW-1:0]          use_li;
    logic                   pref_hit;
    logic                   any_nonempty;
    logic [PAGE_W-1:0]      use_head;
    logic                   do_free;
    logic                   do_bad;
    logic                   do_oom;
    logic                   do_issue;
    logic                   do_pop;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE) && out_free;
    assign take     = q_valid && q_ready;

    assign cmd_li       = q_cmd.list[LW-1:0];
    assign pref_hit     = q_cmd.pref && nonempty_reg[cmd_li];
    assign any_nonempty = |nonempty_reg;

    // lowest-numbered non-empty list
    always_comb begin
        low_li = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--) begin
            if (nonempty_reg[i]) begin
                low_li = LW'(i);
            end
        end
    end

    assign sel_li   = pref_hit ? cmd_li : low_li;
    assign use_li   = (q_cmd.op == OP_FREE) ? cmd_li : sel_li;
    assign use_head = head_reg[use_li];

    assign do_free  = take && (q_cmd.op == OP_FREE);
    assign do_bad   = take && (q_cmd.op == OP_BAD);
    assign do_oom   = take && (q_cmd.op == OP_ALLOC) && !any_nonempty;
    assign do_issue = take && (q_cmd.op == OP_ALLOC) && any_nonempty;
    assign do_pop   = (state_reg == S_POP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nonempty_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (do_free || do_bad || do_oom || do_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (do_free) begin
                        nonempty_reg[cmd_li] <= 1'b1;
                    end
                    if (do_issue) begin
                        state_reg <= S_POP;
                    end
                end
                S_POP: begin
                    nonempty_reg[pop_sel_reg] <= rd_data_reg[PAGE_W];
                    state_reg                 <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_free) begin
            head_reg[cmd_li] <= q_cmd.page;
            m_status_reg     <= ST_OK;
            m_page_reg       <= '0;
        end
        if (do_bad) begin
            m_status_reg <= ST_BAD_FREE;
            m_page_reg   <= '0;
        end
        if (do_oom) begin
            m_status_reg <= ST_OOM;
            m_page_reg   <= '0;
        end
        if (do_issue) begin
            pop_sel_reg <= sel_li;
        end
        if (do_pop) begin
            // hand out the old head, advance to its successor
            head_reg[pop_sel_reg] <= rd_data_reg[PAGE_W-1:0];
            m_status_reg          <= ST_OK;
            m_page_reg            <= head_reg[pop_sel_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_free) begin
            link_mem[AW'(q_cmd.page)] <= nonempty_reg[cmd_li] ?
                                         {1'b1, use_head} : '0;
        end
        if (do_issue) begin
            rd_data_reg <= link_mem[AW'(use_head)];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_page_out = m_page_reg;

    a_pop_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> !m_valid_reg)
        else $error("pop completes into an occupied output slot");

    a_pop_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |=> (state_reg == S_IDLE) && m_valid_reg)
        else $error("pop did not finish in one cycle");

    a_oom_only_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_oom |=> (m_status_reg == ST_OOM) && (nonempty_reg == '0))
        else $error("out of memory reported with a list holding pages");

endmodule

// ===== rtl/per_cpu_free_page_allocator.sv =====
// Per-CPU free-list page allocator.
// Requests arrive on the s_ channel (s_valid/s_ready): s_req_type picks
// allocate or free, s_cpu_id names the preferred list on allocate, s_page_in
// is the page to free. Every request returns exactly one beat on the m_
// channel (m_valid/m_ready) with m_status and m_page_out, in request order.
// The free floor register is written over cfg_valid/cfg_ready/cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce; cfg_ready is always high. The front end classifies a
// request in the cycle it is accepted and parks it in a two-entry queue. The
// list engine retires a free, a rejected free or an out-of-memory allocate as
// it takes it; an allocate that finds a page passes a pop state: the link
// memory read at the list head is registered and the head is updated from it
// in the following cycle. While m_ready is high, one free is taken per cycle;
// a successful allocate stalls the next request. A stalled m_ready holds the
// result in the output register; the queue keeps taking requests until its
// two entries are full, then s_ready drops. Synchronous reset (aresetn low)
// empties every list and the queue and sets the floor to 0; the link memory
// is not cleared, software refills the lists with free requests.
module per_cpu_free_page_allocator import pcfa_pkg::*; #(
    parameter int NUM_PAGES = DEF_NUM_PAGES,
    parameter int NUM_LISTS = DEF_NUM_LISTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PAGE_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [CPU_W-1:0]    s_cpu_id,
    input  logic [PAGE_W-1:0]   s_page_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [PAGE_W-1:0]   m_page_out
);

    logic   push_valid;
    logic   push_ready;
    cmd_t   push_data;
    logic   pop_valid;
    logic   pop_ready;
    cmd_t   pop_data;

    pcfa_front #(
        .NUM_PAGES (NUM_PAGES),
        .NUM_LISTS (NUM_LISTS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_cpu_id     (s_cpu_id),
        .s_page_in    (s_page_in),
        .q_push_valid (push_valid),
        .q_push_ready (push_ready),
        .q_push_data  (push_data)
    );

    pcfa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pcfa_back #(
        .NUM_PAGES (NUM_PAGES),
        .NUM_LISTS (NUM_LISTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_cmd      (pop_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_page_out (m_page_out)
    );

endmodule

// ===== verif/per_cpu_free_page_allocator_test.sv =====
module per_cpu_free_page_allocator_test import pcfa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PAGES      = DEF_NUM_PAGES;
    localparam int N_LISTS      = DEF_NUM_LISTS;
    localparam int PART_PAGES   = N_PAGES / N_LISTS;
    localparam int LIMIT_CYCLES = 100000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
    } beat_t;

    typedef struct packed {
        logic                set_floor;  // row writes the floor instead of sending a request
        logic                req_type;
        logic [CPU_W-1:0]    cpu;
        logic [PAGE_W-1:0]   page;
        logic                fixed;      // expected beat given in the row
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page_out;
    } step_row_t;

    // Rows from EARLY_ROWS on run after the random part: the double free leaves a
    // cycle that keeps its list from ever draining, so out of memory is gone after it.
    localparam int N_ROWS     = 29;
    localparam int EARLY_ROWS = 24;
    localparam step_row_t DIRECTED [N_ROWS] = '{
        '{1'b0, REQ_ALLOC, 3'd0, 15'h0000, 1'b1, ST_OOM,      15'd0},
        '{1'b0, REQ_ALLOC, 3'd7, 15'h0000, 1'b1, ST_OOM,      15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h0000, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd5, 15'h7FFF, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd2, 15'h1000, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd7, 15'h1001, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd7, 15'h7FFF, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd1, 15'h0000, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd1, 15'h5555, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd4, 15'h2AAA, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd4, 15'h0000, 1'b1, ST_OOM,      15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h5555, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h2AAA, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd3, 15'h0000, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd5, 15'h0000, 1'b0, ST_OK,       15'd0},
        '{1'b1, REQ_FREE,  3'd0, 15'h7FFF, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h7FFE, 1'b1, ST_BAD_FREE, 15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h0000, 1'b1, ST_BAD_FREE, 15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h7FFF, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd0, 15'h0000, 1'b0, ST_OK,       15'd0},
        '{1'b1, REQ_FREE,  3'd0, 15'h4000, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h3FFF, 1'b1, ST_BAD_FREE, 15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h4000, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd2, 15'h0000, 1'b0, ST_OK,       15'd0},
        '{1'b1, REQ_FREE,  3'd0, 15'h0000, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h6123, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_FREE,  3'd0, 15'h6123, 1'b1, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd6, 15'h0000, 1'b0, ST_OK,       15'd0},
        '{1'b0, REQ_ALLOC, 3'd6, 15'h0000, 1'b0, ST_OK,       15'd0}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PAGE_W-1:0]   cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_req_type;
    logic [CPU_W-1:0]    s_cpu_id;
    logic [PAGE_W-1:0]   s_page_in;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [PAGE_W-1:0]   m_page_out;

    // predicted allocator state
    logic [PAGE_W-1:0]   floor_reg;
    logic [PAGE_W-1:0]   list_top [N_LISTS];
    logic                has_pages [N_LISTS];
    logic [PAGE_W:0]     succ_link [N_PAGES];
    int unsigned         free_copies [N_PAGES];
    logic [PAGE_W-1:0]   handed_out [$];
    logic [PAGE_W-1:0]   last_freed;

    beat_t               pending_beats [$];
    beat_t               want;
    int unsigned         mismatches;
    int unsigned         cycle_count;
    logic                s_idle;
    logic                m_idle;

    per_cpu_free_page_allocator #(
        .NUM_PAGES (N_PAGES),
        .NUM_LISTS (N_LISTS)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_cpu_id   (s_cpu_id),
        .s_page_in  (s_page_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_page_out (m_page_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic beat_t serve_request(input logic rt, input logic [CPU_W-1:0] cpu,
                                            input logic [PAGE_W-1:0] pg);
        beat_t r;
        int    li;
        int    i;
        r.status = ST_OK;
        r.page   = '0;
        li       = -1;
        if (rt == REQ_FREE) begin
            if (pg < floor_reg) begin
                r.status = ST_BAD_FREE;
            end else begin
                li = int'(pg) * N_LISTS / N_PAGES;
                succ_link[pg] = has_pages[li] ? {1'b1, list_top[li]} : '0;
                list_top[li]  = pg;
                has_pages[li] = 1'b1;
                free_copies[pg]++;
                last_freed = pg;
            end
        end else begin
            if (cpu < N_LISTS && has_pages[cpu]) begin
                li = cpu;
            end else begin
                // lowest non-empty list wins
                for (i = N_LISTS - 1; i >= 0; i--)
                    if (has_pages[i]) li = i;
            end
            if (li < 0) begin
                r.status = ST_OOM;
            end else begin
                r.page        = list_top[li];
                has_pages[li] = succ_link[r.page][PAGE_W];
                list_top[li]  = succ_link[r.page][PAGE_W-1:0];
                if (free_copies[r.page] != 0) free_copies[r.page]--;
                handed_out.push_back(r.page);
                if (handed_out.size() > 64) void'(handed_out.pop_front());
            end
        end
        return r;
    endfunction

    task automatic send_req(input logic rt, input logic [CPU_W-1:0] cpu,
                            input logic [PAGE_W-1:0] pg, input logic fixed, input beat_t typed);
        beat_t predicted;
        @(negedge aclk);
        while (s_idle && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rt;
        s_cpu_id   <= cpu;
        s_page_in  <= pg;
        predicted = serve_request(rt, cpu, pg);
        pending_beats.push_back(fixed ? typed : predicted);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold the sender until every outstanding beat has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_floor(input logic [PAGE_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        floor_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_rows(input int first, input int last);
        int    k;
        beat_t typed;
        for (k = first; k <= last; k++) begin
            if (DIRECTED[k].set_floor) begin
                set_floor(DIRECTED[k].page);
            end else begin
                typed.status = DIRECTED[k].status;
                typed.page   = DIRECTED[k].page_out;
                send_req(DIRECTED[k].req_type, DIRECTED[k].cpu, DIRECTED[k].page,
                         DIRECTED[k].fixed, typed);
            end
        end
    endtask

    task automatic run_phase(input int n_items, input int alloc_pct, input logic dbl_ok);
        logic [N_LISTS-1:0] part_mask;
        logic [PAGE_W-1:0]  pg;
        int                 k;
        int                 part;
        int                 pick;
        int                 idx;
        part_mask = N_LISTS'($urandom_range(1, (1 << N_LISTS) - 1));
        for (k = 0; k < n_items; k++) begin
            if (k == n_items / 2) wait_drained();
            if ($urandom_range(99) < alloc_pct) begin
                send_req(REQ_ALLOC, CPU_W'($urandom_range(7)), PAGE_W'($urandom), 1'b0, '0);
            end else begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    pg = PAGE_W'($urandom);
                end else if (pick < 55 && handed_out.size() != 0) begin
                    // return a page that was handed out earlier
                    idx = $urandom_range(handed_out.size() - 1);
                    pg  = handed_out[idx];
                    handed_out.delete(idx);
                end else begin
                    part = $urandom_range(N_LISTS - 1);
                    while (!part_mask[part]) part = $urandom_range(N_LISTS - 1);
                    pg = PAGE_W'(part * PART_PAGES + $urandom_range(PART_PAGES - 1));
                end
                if (dbl_ok && $urandom_range(99) < 3) pg = last_freed;
                // keep the lists free of cycles unless this phase allows double frees
                while (!dbl_ok && pg >= floor_reg && free_copies[pg] != 0)
                    pg = PAGE_W'($urandom);
                send_req(REQ_FREE, CPU_W'($urandom_range(7)), pg, 1'b0, '0);
            end
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= !m_idle || $urandom_range(99) >= 12;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected: status %0d page %0d",
                         $time, m_status, m_page_out);
                mismatches++;
            end else begin
                want = pending_beats.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_status);
                    mismatches++;
                end
                if (m_page_out !== want.page) begin
                    $display("%0t: page_out expected %0d actual %0d",
                             $time, want.page, m_page_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_req_type  = REQ_ALLOC;
        s_cpu_id    = '0;
        s_page_in   = '0;
        s_idle      = 1'b1;
        m_idle      = 1'b1;
        floor_reg   = '0;
        last_freed  = '0;
        for (int i = 0; i < N_LISTS; i++) begin
            list_top[i]  = '0;
            has_pages[i] = 1'b0;
        end
        for (int i = 0; i < N_PAGES; i++) begin
            succ_link[i]   = '0;
            free_copies[i] = 0;
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        run_rows(0, EARLY_ROWS - 1);

        set_floor('0);
        run_phase(300, 40, 1'b0);

        // long stretch with both sides streaming
        set_floor(15'h2000);
        s_idle = 1'b0;
        m_idle = 1'b0;
        run_phase(250, 55, 1'b0);
        s_idle = 1'b1;
        m_idle = 1'b1;

        set_floor(PAGE_W'($urandom_range(1, N_PAGES - 2)));
        run_phase(250, 50, 1'b0);

        set_floor(15'h7FFF);
        run_phase(60, 50, 1'b0);

        set_floor('0);
        run_phase(240, 45, 1'b1);

        run_rows(EARLY_ROWS, N_ROWS - 1);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
